// File: rtl/core/fsfp_pkg.sv
// Shared types, field widths, codes and reset values of the fixed-step frame pacer.
package fsfp_pkg;

    localparam int NOW_W       = 63;
    localparam int RATE_W      = 10;
    localparam int OP_W        = 2;
    localparam int PERIOD_W    = 30;
    localparam int THR_W       = 32;
    localparam int TICK_W      = 5;
    localparam int PHASE_W     = 17;
    localparam int Q_BITS      = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 24;

    localparam int MAX_TICKS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(16666666);
    localparam logic [THR_W-1:0]    GAP_RST    = THR_W'(250000000);
    localparam logic [RATE_W-1:0]   BASE_RST   = RATE_W'(60);
    localparam logic [RATE_W-1:0]   MAXR_RST   = RATE_W'(240);
    localparam logic [PHASE_W-1:0]  PHASE_ONE  = PHASE_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_COMMIT = 2'd1,
        OP_PHASE  = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_GAP    = 2'd1,
        CFG_BASE   = 2'd2,
        CFG_MAXR   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RENDER,
        ST_TICK,
        ST_COMMIT,
        ST_ELAPSE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/fsfp_div.sv
// Restoring divider that forms the Q16 phase fraction, one quotient bit per cycle.
module fsfp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fsfp_pkg::PERIOD_W-1:0] dividend,
    input  logic [fsfp_pkg::PERIOD_W-1:0] divisor,
    output logic                         done,
    output logic [fsfp_pkg::Q_BITS-1:0]   quotient
);
    import fsfp_pkg::*;

    localparam int QCW = $clog2(Q_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [QCW-1:0]      cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [Q_BITS-1:0]   quo_reg, quo_next;
    logic [PERIOD_W:0]   rem_dbl;
    logic [PERIOD_W:0]   rem_sub;
    logic                fits;

    assign rem_dbl = {rem_reg, 1'b0};
    assign fits    = rem_dbl >= {1'b0, divisor};
    assign rem_sub = rem_dbl - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[PERIOD_W-1:0] : rem_dbl[PERIOD_W-1:0];
            quo_next = {quo_reg[Q_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCW'(Q_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/fixed_step_frame_pacer.sv
// Fixed-step frame pacer: top level with the bit-serial time datapath and sequencer.
//
// The pacer handles one item at a time; s_axis_tready is high only while it is idle,
// and a finished result waits in the output register without blocking the next beat.
// All time arithmetic runs one bit per cycle through serial adders, in passes over a
// timestamp. A frame sample at or below the base rate, and a commit or a phase query
// while interpolation is off, go straight to the done state. A commit, an explicit
// reset, a re-seeding frame sample and a phase query that ends at zero or one each make
// a serial pass over a timestamp. A catch-up sample makes a render pass and then a
// catch-up pass per step, up to MaxTicks steps, and a phase query that needs the
// divider makes its elapsed-time pass and then waits for the divider. An item that
// finishes while the previous result still waits holds the input until that result
// is taken.
module fixed_step_frame_pacer #(
    parameter int MaxTicks  = fsfp_pkg::MAX_TICKS_DEF,
    parameter int TimeWidth = fsfp_pkg::TIME_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fsfp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fsfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ns [62:0], target_rate [72:63], zero pad [79:73]
    input  logic [fsfp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation [1:0]
    input  logic [fsfp_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tick_count [4:0], interp_reset [5], phase_q16 [22:6], interp_enabled [23]
    output logic [fsfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import fsfp_pkg::*;

    localparam int W    = TimeWidth;
    localparam int CW   = $clog2(TimeWidth);
    localparam int TCW  = ($clog2(MaxTicks + 1) > TICK_W) ? $clog2(MaxTicks + 1) : TICK_W;
    localparam int PIW  = $clog2(PERIOD_W);
    localparam int TIW  = $clog2(THR_W);

    // Configuration registers.
    logic [PERIOD_W-1:0] period_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [RATE_W-1:0]   base_reg;
    logic [RATE_W-1:0]   maxr_reg;

    // Control and persistent state.
    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic              active_reg, active_next;
    logic [RATE_W-1:0] last_rate_reg, last_rate_next;
    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      prev_reg, prev_next;
    logic [W-1:0]      snap_reg, snap_next;
    logic [TCW-1:0]    ticks_reg, ticks_next;

    // Per-item working registers.
    op_t                op_reg, op_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               ien_reg, ien_next;
    logic [W-1:0]       now_reg, now_next;
    logic [W-1:0]       aux_reg, aux_next;
    logic [W-1:0]       proj_reg, proj_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               c0_reg, c0_next;
    logic               c1_reg, c1_next;
    logic               cmp_reg, cmp_next;
    logic               nz_reg, nz_next;
    logic               flag_reg, flag_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Serial operand selection and full adders.
    logic x0, y0, x1, y1;
    logic s0, k0, s1, k1;
    logic per_bit, thr_bit, last_bit;
    logic [CW:0] cnt_ext;

    // Input beat decode.
    logic [63:0]       now_ext;
    logic [W-1:0]      now_in;
    logic [RATE_W-1:0] rate_in;
    logic [RATE_W-1:0] rate_hi;
    logic [RATE_W-1:0] rate_clamp;
    logic              accept;

    logic                div_start;
    logic                div_done;
    logic [Q_BITS-1:0]   div_quo;

    assign now_ext    = 64'(s_axis_tdata[NOW_W-1:0]);
    assign now_in     = now_ext[W-1:0];
    assign rate_in    = s_axis_tdata[NOW_W +: RATE_W];
    assign rate_hi    = (maxr_reg > base_reg) ? maxr_reg : base_reg;
    assign rate_clamp = (rate_in < base_reg) ? base_reg :
                        (rate_in > rate_hi) ? rate_hi : rate_in;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt_ext  = {1'b0, cnt_reg};
    assign per_bit  = (cnt_ext < (CW + 1)'(PERIOD_W)) ? period_reg[cnt_reg[PIW-1:0]] : 1'b0;
    assign thr_bit  = (cnt_ext < (CW + 1)'(THR_W)) ? thr_reg[cnt_reg[TIW-1:0]] : 1'b0;
    assign last_bit = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        x0 = 1'b0;
        y0 = 1'b0;
        x1 = 1'b0;
        y1 = 1'b0;
        unique case (state_reg)
            ST_RENDER:
            begin
                x0 = now_reg[0];
                y0 = ~per_bit;
                x1 = now_reg[0];
                y1 = ~prev_reg[0];
            end
            ST_TICK:
            begin
                x0 = proj_reg[0];
                y0 = ~aux_reg[0];
                x1 = proj_reg[0];
                y1 = per_bit;
            end
            ST_COMMIT:
            begin
                x1 = snap_reg[0];
                y1 = per_bit;
            end
            ST_ELAPSE:
            begin
                x0 = now_reg[0];
                y0 = ~snap_reg[0];
            end
            default:
            begin
                x0 = 1'b0;
            end
        endcase
    end

    assign s0 = x0 ^ y0 ^ c0_reg;
    assign k0 = (x0 & y0) | (x0 & c0_reg) | (y0 & c0_reg);
    assign s1 = x1 ^ y1 ^ c1_reg;
    assign k1 = (x1 & y1) | (x1 & c1_reg) | (y1 & c1_reg);

    fsfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (aux_next[PERIOD_W-1:0]),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        active_next    = active_reg;
        last_rate_next = last_rate_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        prev_next      = prev_reg;
        snap_next      = snap_reg;
        ticks_next     = ticks_reg;
        op_next        = op_reg;
        rate_next      = rate_reg;
        ien_next       = ien_reg;
        now_next       = now_reg;
        aux_next       = aux_reg;
        proj_next      = proj_reg;
        cnt_next       = cnt_reg + 1'b1;
        c0_next        = k0;
        c1_next        = k1;
        cmp_next       = cmp_reg;
        nz_next        = nz_reg;
        flag_next      = flag_reg;
        phase_next     = phase_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                c0_next  = 1'b1;
                c1_next  = 1'b0;
                cmp_next = 1'b0;
                nz_next  = 1'b0;
                if (accept)
                begin
                    op_next    = op_t'(s_axis_tuser);
                    rate_next  = rate_clamp;
                    ien_next   = rate_clamp > base_reg;
                    now_next   = now_in;
                    ticks_next = '0;
                    flag_next  = 1'b0;
                    phase_next = '0;
                    unique case (op_t'(s_axis_tuser))
                        OP_SAMPLE:
                        begin
                            if (rate_clamp <= base_reg)
                            begin
                                prev_next      = now_in;
                                snap_next      = now_in;
                                init_next      = 1'b1;
                                last_rate_next = rate_clamp;
                                active_next    = 1'b0;
                                ticks_next     = TCW'(1);
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                if (!init_reg)
                                begin
                                    prev_next = now_in;
                                    snap_next = now_in;
                                    init_next = 1'b1;
                                end
                                c1_next    = 1'b1;
                                state_next = ST_RENDER;
                            end
                        end
                        OP_COMMIT:
                        begin
                            state_next = active_reg ? ST_COMMIT : ST_DONE;
                        end
                        OP_PHASE:
                        begin
                            if (active_reg)
                            begin
                                cmp_next   = 1'b1;
                                state_next = ST_ELAPSE;
                            end
                            else
                            begin
                                phase_next = PHASE_ONE;
                                state_next = ST_DONE;
                            end
                        end
                        OP_RESET:
                        begin
                            c1_next    = 1'b1;
                            state_next = ST_RENDER;
                        end
                    endcase
                end
            end

            ST_RENDER:
            begin
                // Render time into aux, gap against the previous sample compared on the fly.
                aux_next  = {s0, aux_reg[W-1:1]};
                now_next  = {now_reg[0], now_reg[W-1:1]};
                prev_next = {prev_reg[0], prev_reg[W-1:1]};
                cmp_next  = (s1 & ~thr_bit) | (~(s1 ^ thr_bit) & cmp_reg);
                if (last_bit)
                begin
                    cnt_next  = '0;
                    prev_next = now_next;
                    init_next = 1'b1;
                    if (op_reg == OP_RESET)
                    begin
                        snap_next  = aux_next;
                        flag_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (rate_reg != last_rate_reg)
                    begin
                        snap_next      = aux_next;
                        last_rate_next = rate_reg;
                        active_next    = 1'b1;
                        flag_next      = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        if (!s1 && cmp_next)
                        begin
                            snap_next  = aux_next;
                            flag_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            proj_next  = snap_reg;
                            c0_next    = 1'b1;
                            c1_next    = 1'b0;
                            state_next = ST_TICK;
                        end
                    end
                end
            end

            ST_TICK:
            begin
                // One catch-up step: sign of projection minus render, projection plus period.
                proj_next = {s1, proj_reg[W-1:1]};
                aux_next  = {aux_reg[0], aux_reg[W-1:1]};
                if (last_bit)
                begin
                    cnt_next = '0;
                    c0_next  = 1'b1;
                    c1_next  = 1'b0;
                    if (s0)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                        if (ticks_next == TCW'(MaxTicks))
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_COMMIT:
            begin
                snap_next = {s1, snap_reg[W-1:1]};
                if (last_bit)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_ELAPSE:
            begin
                // Elapsed time since the snapshot, checked for zero and against one period.
                aux_next  = {s0, aux_reg[W-1:1]};
                now_next  = {now_reg[0], now_reg[W-1:1]};
                snap_next = {snap_reg[0], snap_reg[W-1:1]};
                cmp_next  = (s0 & ~per_bit) | (~(s0 ^ per_bit) & cmp_reg);
                nz_next   = nz_reg | s0;
                if (last_bit)
                begin
                    cnt_next = '0;
                    if (s0 || !nz_next)
                    begin
                        phase_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (cmp_next)
                    begin
                        phase_next = PHASE_ONE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    phase_next = PHASE_W'(div_quo);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {ien_reg, phase_reg, flag_reg, ticks_reg[TICK_W-1:0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            thr_reg    <= GAP_RST;
            base_reg   <= BASE_RST;
            maxr_reg   <= MAXR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_GAP:    thr_reg    <= cfg_wdata[THR_W-1:0];
                CFG_BASE:   base_reg   <= cfg_wdata[RATE_W-1:0];
                CFG_MAXR:   maxr_reg   <= cfg_wdata[RATE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            init_reg      <= 1'b0;
            active_reg    <= 1'b0;
            last_rate_reg <= BASE_RST;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            snap_reg      <= '0;
            ticks_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            active_reg    <= active_next;
            last_rate_reg <= last_rate_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            snap_reg      <= snap_next;
            ticks_reg     <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rate_reg     <= rate_next;
        ien_reg      <= ien_next;
        now_reg      <= now_next;
        aux_reg      <= aux_next;
        proj_reg     <= proj_next;
        cnt_reg      <= cnt_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        cmp_reg      <= cmp_next;
        nz_reg       <= nz_next;
        flag_reg     <= flag_next;
        phase_reg    <= phase_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_ticks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg <= TCW'(MaxTicks))
        else $error("tick counter ran past its limit");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item did not reach the output register");

    a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg[TICK_W + 1 +: PHASE_W] <= PHASE_ONE)
        else $error("phase above one");

    a_reseed_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[TICK_W] |-> out_data_reg[TICK_W-1:0] == '0)
        else $error("reseed beat carries a tick count");

endmodule

// File: sim/testbench.sv
// Self-checking testbench of the fixed-step frame pacer: directed and random beats against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsfp_pkg::*;

    localparam int TIMEOUT_CYCLES       = 8_000_000;
    localparam int HOLD_OFF_CYCLES      = 3000;
    localparam int RAND_BEATS_PER_PHASE = 200;
    localparam int NUM_PHASES           = 7;
    localparam int SETTLE_CYCLES        = 1500;
    localparam logic [NOW_W-1:0] NOW_TOP = '1;

    typedef struct packed {
        logic               interp_enabled;
        logic [PHASE_W-1:0] phase_q16;
        logic               interp_reset;
        logic [TICK_W-1:0]  tick_count;
    } pace_result_t;

    class frame_pacing_check;
        logic [PERIOD_W-1:0] period_ns;
        logic [THR_W-1:0]    gap_limit_ns;
        logic [RATE_W-1:0]   base_rate;
        logic [RATE_W-1:0]   max_rate;
        logic [63:0]         prev_sample_ns;
        logic [63:0]         snapshot_ns;
        logic [RATE_W-1:0]   last_rate;
        bit                  primed;
        bit                  interp_on;
        pace_result_t        awaited_results[$];
        int                  mismatches;

        function new();
            period_ns      = PERIOD_RST;
            gap_limit_ns   = GAP_RST;
            base_rate      = BASE_RST;
            max_rate       = MAXR_RST;
            prev_sample_ns = '0;
            snapshot_ns    = '0;
            last_rate      = BASE_RST;
            primed         = 1'b0;
            interp_on      = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PERIOD: period_ns    = value[PERIOD_W-1:0];
                CFG_GAP:    gap_limit_ns = value[THR_W-1:0];
                CFG_BASE:   base_rate    = value[RATE_W-1:0];
                CFG_MAXR:   max_rate     = value[RATE_W-1:0];
                default:    ;
            endcase
        endfunction

        function void reseed(input logic [63:0] t_now);
            prev_sample_ns = t_now;
            snapshot_ns    = t_now - period_ns;
            primed         = 1'b1;
        endfunction

        function pace_result_t accept_beat(input op_t op, input logic [NOW_W-1:0] t_in,
                                           input logic [RATE_W-1:0] rate_req);
            logic [63:0]       t_now;
            logic [63:0]       gap;
            logic [63:0]       proj;
            logic [63:0]       render;
            logic [63:0]       diff;
            logic [63:0]       elapsed;
            logic [63:0]       quotient;
            logic [RATE_W-1:0] ceiling;
            logic [RATE_W-1:0] rate;
            int                ticks;
            pace_result_t      res;

            t_now   = {1'b0, t_in};
            ceiling = (max_rate > base_rate) ? max_rate : base_rate;
            rate    = (rate_req < base_rate) ? base_rate : rate_req;
            if (rate > ceiling)
                rate = ceiling;
            res   = '0;
            ticks = 0;
            res.interp_enabled = (rate > base_rate);

            case (op)
                OP_SAMPLE:
                begin
                    if (rate <= base_rate)
                    begin
                        prev_sample_ns = t_now;
                        snapshot_ns    = t_now;
                        primed         = 1'b1;
                        last_rate      = rate;
                        interp_on      = 1'b0;
                        ticks          = 1;
                    end
                    else
                    begin
                        if (!primed)
                        begin
                            primed         = 1'b1;
                            prev_sample_ns = t_now;
                            snapshot_ns    = t_now;
                        end
                        if (rate != last_rate)
                        begin
                            reseed(t_now);
                            last_rate        = rate;
                            interp_on        = 1'b1;
                            res.interp_reset = 1'b1;
                        end
                        else
                        begin
                            gap            = t_now - prev_sample_ns;
                            interp_on      = 1'b1;
                            prev_sample_ns = t_now;
                            if (!gap[63] && gap > gap_limit_ns)
                            begin
                                snapshot_ns      = t_now - period_ns;
                                res.interp_reset = 1'b1;
                            end
                            else
                            begin
                                proj   = snapshot_ns;
                                render = t_now - period_ns;
                                diff   = proj - render;
                                while (ticks < MAX_TICKS_DEF && diff[63])
                                begin
                                    proj  = proj + period_ns;
                                    ticks = ticks + 1;
                                    diff  = proj - render;
                                end
                            end
                        end
                    end
                end
                OP_COMMIT:
                begin
                    if (interp_on)
                        snapshot_ns = snapshot_ns + period_ns;
                end
                OP_PHASE:
                begin
                    if (!interp_on)
                        res.phase_q16 = PHASE_ONE;
                    else
                    begin
                        elapsed = t_now - snapshot_ns;
                        if (elapsed[63] || elapsed == 0)
                            res.phase_q16 = '0;
                        else if (elapsed >= period_ns)
                            res.phase_q16 = PHASE_ONE;
                        else
                        begin
                            quotient      = (elapsed << Q_BITS) / 64'(period_ns);
                            res.phase_q16 = quotient[PHASE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    reseed(t_now);
                    res.interp_reset = 1'b1;
                end
            endcase

            res.tick_count = TICK_W'(ticks);
            awaited_results.push_back(res);
            return res;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_beat(input logic [OUT_DATA_W-1:0] beat);
            pace_result_t got;
            pace_result_t want;

            got = beat;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result beat %h arrived with nothing outstanding", beat));
                return;
            end
            want = awaited_results.pop_front();
            if (got.tick_count !== want.tick_count)
                report($sformatf("tick_count %0d, expected %0d", got.tick_count,
                                 want.tick_count));
            if (got.interp_reset !== want.interp_reset)
                report($sformatf("interp_reset %b, expected %b", got.interp_reset,
                                 want.interp_reset));
            if (got.phase_q16 !== want.phase_q16)
                report($sformatf("phase_q16 %0d, expected %0d", got.phase_q16,
                                 want.phase_q16));
            if (got.interp_enabled !== want.interp_enabled)
                report($sformatf("interp_enabled %b, expected %b", got.interp_enabled,
                                 want.interp_enabled));
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    frame_pacing_check pacer_sb;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_requests  = 0;
    int                hold_served    = 0;
    int                hold_left      = 0;
    int                beats_sent     = 0;
    int                cycle_count    = 0;
    logic [NOW_W-1:0]  wall_ns        = '0;
    logic [RATE_W-1:0] steady_rate    = '0;

    fixed_step_frame_pacer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit coin(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic logic [NOW_W-1:0] frame_step(input logic [PERIOD_W-1:0] p);
        if (p == 0)
            return NOW_W'($urandom_range(1000, 0));
        return NOW_W'((64'(p) * $urandom_range(9, 0)) >> 2);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pacer_sb.check_beat(m_axis_tdata);
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !coin(recv_stall_pct);
    end

    task automatic send_beat(input op_t op, input logic [NOW_W-1:0] t,
                             input logic [RATE_W-1:0] rate, output pace_result_t res);
        while (coin(send_idle_pct))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - NOW_W - RATE_W){1'b0}}, rate, t};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = pacer_sb.accept_beat(op, t, rate);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pacer_sb.awaited_results.size() != 0);
    endtask

    task automatic program_pacer(input logic [CFG_DATA_W-1:0] period, gap, base, maxr);
        cfg_idx_t              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];

        regs = '{CFG_PERIOD, CFG_GAP, CFG_BASE, CFG_MAXR};
        vals = '{period, gap, base, maxr};
        foreach (regs[i])
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            pacer_sb.write_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        logic [NOW_W-1:0] t0;
        logic [NOW_W-1:0] p;
        pace_result_t     res;

        t0 = NOW_W'(1_000_000_000);
        p  = NOW_W'(PERIOD_RST);
        send_beat(OP_PHASE, '0, '0, res);
        send_beat(OP_COMMIT, NOW_TOP, '1, res);
        send_beat(OP_SAMPLE, t0, RATE_W'(30), res);
        send_beat(OP_SAMPLE, t0 + p, '0, res);
        send_beat(OP_SAMPLE, t0 + 2 * p, '1, res);
        send_beat(OP_SAMPLE, t0 + 2 * p + p / 2, MAXR_RST, res);
        send_beat(OP_COMMIT, t0, MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns - 1), MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns), MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns + 1), MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns) + p / 3, MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns) + p - 1, MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns) + p, MAXR_RST, res);
        send_beat(OP_PHASE, NOW_W'(pacer_sb.snapshot_ns) + 5 * p, MAXR_RST, res);
        // Snapshot falls behind without commits until the tick count saturates.
        send_beat(OP_SAMPLE, t0 + 16 * p, MAXR_RST, res);
        send_beat(OP_SAMPLE, t0 + 30 * p, MAXR_RST, res);
        send_beat(OP_SAMPLE, t0 + 30 * p + NOW_W'(300_000_000), MAXR_RST, res);
        send_beat(OP_SAMPLE, t0, MAXR_RST, res);
        send_beat(OP_RESET, t0 + 5 * p, RATE_W'(500), res);
        send_beat(OP_SAMPLE, NOW_TOP - p / 2, MAXR_RST, res);
        send_beat(OP_SAMPLE, NOW_W'(100), MAXR_RST, res);
        send_beat(OP_RESET, '0, '1, res);
        send_beat(OP_PHASE, NOW_TOP, '1, res);
        send_beat(OP_SAMPLE, '0, '0, res);
    endtask

    task automatic random_frames(input int beats);
        int               stop_at;
        int               next_pause;
        int               kind;
        int               commits;
        int               queries;
        logic [NOW_W-1:0] p;
        logic [31:0]      span;
        op_t              noise_op;
        pace_result_t     res;

        stop_at     = beats_sent + beats;
        next_pause  = beats_sent + $urandom_range(90, 40);
        p           = NOW_W'(pacer_sb.period_ns);
        span        = (p == 0) ? 32'd1000 : 32'(2 * p);
        steady_rate = RATE_W'($urandom_range(1023, 0));
        while (beats_sent < stop_at)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 5)
                steady_rate = RATE_W'($urandom_range(1023, 0));
            if (kind < 75)
            begin
                if (kind >= 70)
                    wall_ns = wall_ns + pacer_sb.gap_limit_ns + 1
                              + NOW_W'($urandom_range(span, 0));
                else if (kind >= 66)
                    wall_ns = wall_ns - frame_step(pacer_sb.period_ns);
                else
                    wall_ns = wall_ns + frame_step(pacer_sb.period_ns);
                send_beat(OP_SAMPLE, wall_ns, steady_rate, res);
                commits = (kind % 8 == 0) ? 0 : int'(res.tick_count);
                queries = $urandom_range(2, 0);
                repeat (commits)
                    send_beat(OP_COMMIT, NOW_W'({$urandom, $urandom}), steady_rate, res);
                repeat (queries)
                    send_beat(OP_PHASE, wall_ns + NOW_W'($urandom_range(span, 0)) - p,
                              steady_rate, res);
            end
            else if (kind < 80)
                send_beat(OP_RESET, wall_ns, steady_rate, res);
            else if (kind < 83)
                wall_ns = NOW_TOP - NOW_W'($urandom_range(span, 0));
            else
            begin
                noise_op = op_t'($urandom_range(3, 0));
                if (coin(50))
                    send_beat(noise_op, NOW_W'({$urandom, $urandom}),
                              RATE_W'($urandom_range(1023, 0)), res);
                else
                    send_beat(noise_op, wall_ns + NOW_W'($urandom_range(span, 0)) - p,
                              RATE_W'($urandom_range(1023, 0)), res);
            end
            if (beats_sent >= next_pause)
            begin
                drain_results();
                next_pause = beats_sent + $urandom_range(90, 40);
            end
        end
    endtask

    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        pacer_sb.report($sformatf("run stopped after %0d cycles, %0d results outstanding",
                                  cycle_count, pacer_sb.awaited_results.size()));
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        pacer_sb = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        drain_results();
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            case (ph)
                0: program_pacer(32'(PERIOD_RST), 32'(GAP_RST), 32'(BASE_RST), 32'(MAXR_RST));
                1: program_pacer(32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1023);
                2: program_pacer(32'd1, 32'd100, 32'd100, 32'd200);
                3: program_pacer(32'd5000, 32'd60000, 32'd1023, 32'd1);
                4: program_pacer(32'd0, 32'd0, 32'd0, 32'd1023);
                default:
                    program_pacer($urandom_range(32'h0010_0000, 100),
                                  $urandom_range(32'hFFFF_FFFF, 1),
                                  $urandom_range(1023, 0), $urandom_range(1023, 0));
            endcase
            if (ph == 0)
                hold_requests++;
            random_frames(RAND_BEATS_PER_PHASE);
            drain_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pacer_sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/fsfp_pkg.sv
rtl/core/fsfp_div.sv
rtl/core/fixed_step_frame_pacer.sv
sim/testbench.sv
